@@ rtl/ele_pkg.sv @@
package ele_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 5;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;

    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_END     = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    localparam t_byte CH_BS    = 8'h08;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_LF    = 8'h0a;
    localparam t_byte CH_CR    = 8'h0d;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_DEL   = 8'h7f;

endpackage

@@ rtl/ele_line_ram.sv @@
module ele_line_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  ele_pkg::t_byte       i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr,
    output ele_pkg::t_byte       o_rdata
);
    import ele_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read enable
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/echoing_line_editor_top.sv @@
// Line editor with echo for a byte-wide receive stream.
// Input channel (i_rx_valid / o_rx_ready) carries one received byte or a
// read-error flag per transaction. Output channel (o_res_valid / i_res_ready)
// carries results: echo bytes, line content bytes, a line end with the
// length, or a read error; o_last_of_run marks the last result of an input.
// One input is handled at a time. A transaction is taken only when the
// editor is idle, even while an earlier result still waits in the output
// register. The input is captured in S_IDLE, and its first result, if any,
// is registered from S_DECODE once the output register is free. A newline
// reads the line back from the line store, which has one read port, so
// readout moves one byte a cycle while the receiver does not stall.
// Reset (synchronous, active low) empties the line and the output register;
// the line store itself is not cleared. When the receiver stalls, the
// current result holds in the output register and the editor waits.
module echoing_line_editor_top #(
    parameter int LINE_CAP = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  ele_pkg::t_byte      i_rx_byte,
    input  logic                i_rx_error,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [1:0]          o_result_kind,
    output ele_pkg::t_byte      o_data_byte,
    output ele_pkg::t_len       o_line_length,
    output logic                o_last_of_run
);
    import ele_pkg::*;

    localparam int FILL_W = $clog2(LINE_CAP);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ERASE,
        S_DUMP,
        S_END
    } t_state;

    t_state             r_state, n_state;
    t_byte              r_ch, n_ch;
    logic               r_err, n_err;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [FILL_W-1:0]  r_idx, n_idx;
    logic               r_step, n_step;
    logic               r_out_valid, n_out_valid;
    t_kind              r_kind, n_kind;
    t_byte              r_data, n_data;
    t_len               r_len, n_len;
    logic               r_last, n_last;

    logic               out_free;
    t_byte              ch_map;
    logic               mem_we, mem_re;
    logic [FILL_W-1:0]  mem_raddr;
    t_byte              mem_rdata;
    logic [FILL_W:0]    fill_inc;

    ele_line_ram #(
        .DEPTH  (LINE_CAP),
        .ADDR_W (FILL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill),
        .i_wdata (ch_map),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || i_res_ready;
    assign fill_inc = {1'b0, r_fill} + (FILL_W+1)'(1);

    always_comb begin
        ch_map = r_ch;
        if (r_ch == CH_CR) begin
            ch_map = CH_LF;
        end else if (r_ch == CH_TAB) begin
            ch_map = CH_SPACE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_err       = r_err;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_res_ready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_len       = r_len;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_idx + FILL_W'(1);

        unique case (r_state)
            S_IDLE: begin
                if (i_rx_valid) begin
                    n_ch    = i_rx_byte;
                    n_err   = i_rx_error;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_data  = ch_map;
                    n_len   = '0;
                    n_kind  = KIND_ECHO;
                    n_last  = 1'b1;
                    if (r_err) begin
                        n_fill      = '0;
                        n_kind      = KIND_ERROR;
                        n_data      = '0;
                        n_out_valid = 1'b1;
                    end else if (ch_map == CH_BS || ch_map == CH_DEL) begin
                        if (r_fill != '0) begin
                            n_fill      = r_fill - FILL_W'(1);
                            n_data      = CH_BS;
                            n_last      = 1'b0;
                            n_step      = 1'b0;
                            n_out_valid = 1'b1;
                            n_state     = S_ERASE;
                        end
                    end else if (ch_map == CH_LF) begin
                        n_last      = 1'b0;
                        n_out_valid = 1'b1;
                        n_idx       = '0;
                        if (r_fill == '0) begin
                            n_state = S_END;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_state   = S_DUMP;
                        end
                    end else if (ch_map >= CH_SPACE
                                 && fill_inc < (FILL_W+1)'(LINE_CAP)) begin
                        mem_we      = 1'b1;
                        n_fill      = fill_inc[FILL_W-1:0];
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_ERASE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ECHO;
                    n_step      = 1'b1;
                    if (!r_step) begin
                        n_data = CH_SPACE;
                    end else begin
                        n_data  = CH_BS;
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CONTENT;
                    n_data      = mem_rdata;
                    n_last      = 1'b0;
                    n_idx       = r_idx + FILL_W'(1);
                    if (r_idx + FILL_W'(1) == r_fill) begin
                        n_state = S_END;
                    end else begin
                        mem_re = 1'b1;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_END;
                    n_data      = '0;
                    n_len       = LEN_W'(r_fill);
                    n_last      = 1'b1;
                    n_fill      = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_ch   <= n_ch;
        r_err  <= n_err;
        r_idx  <= n_idx;
        r_step <= n_step;
        r_kind <= n_kind;
        r_data <= n_data;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign o_rx_ready    = (r_state == S_IDLE);
    assign o_res_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_data_byte   = r_data;
    assign o_line_length = r_len;
    assign o_last_of_run = r_last;

    // line never grows to full capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FILL_W+1)'(r_fill) < (FILL_W+1)'(LINE_CAP))
        else $error("line fill count out of range");

    // readout index stays inside the stored line
    a_dump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> r_idx < r_fill)
        else $error("readout beyond stored line");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_ready |=> r_out_valid && $stable(r_data)
            && $stable(r_kind) && $stable(r_last))
        else $error("pending result overwritten");

    // line end and read error always close a run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_END || r_kind == KIND_ERROR) |-> r_last)
        else $error("line end or error not last of run");

    // no new transaction while a run is still being produced
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_last |-> r_state != S_IDLE)
        else $error("idle in the middle of a run");

endmodule
